// ===== rtl/core/md5sh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package md5sh_pkg;

  // Operation codes carried on the op field of an input beat.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Initial chaining words.
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Padding marker byte and the byte offset where the length field starts.
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  // How the block buffer is presented to the round unit.
  typedef enum logic [1:0] {
    KIND_DATA,  // plain message block
    KIND_PAD,   // last message bytes followed by padding
    KIND_LEN    // zeros followed by the bit length only
  } blk_kind_e;

  // Controls from the sequencer to the round unit.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       fold;
    logic       reinit;
    logic [5:0] rnd;
  } round_ctl_t;

  // Message word index used by a given round.
  function automatic logic [3:0] md5_g(input logic [5:0] rnd);
    logic [3:0] r4;
    logic [3:0] g;
    begin
      r4 = rnd[3:0];
      case (rnd[5:4])
        2'd0:    g = r4;
        2'd1:    g = r4 + {r4[1:0], 2'b00} + 4'd1;
        2'd2:    g = r4 + {r4[2:0], 1'b0} + 4'd5;
        default: g = {r4[0], 3'b000} - r4;
      endcase
      return g;
    end
  endfunction

  // Left rotate amount of a given round.
  function automatic logic [4:0] md5_rot(input logic [5:0] rnd);
    logic [4:0] s;
    begin
      case ({rnd[5:4], rnd[1:0]})
        4'h0: s = 5'd7;
        4'h1: s = 5'd12;
        4'h2: s = 5'd17;
        4'h3: s = 5'd22;
        4'h4: s = 5'd5;
        4'h5: s = 5'd9;
        4'h6: s = 5'd14;
        4'h7: s = 5'd20;
        4'h8: s = 5'd4;
        4'h9: s = 5'd11;
        4'hA: s = 5'd16;
        4'hB: s = 5'd23;
        4'hC: s = 5'd6;
        4'hD: s = 5'd10;
        4'hE: s = 5'd15;
        default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // Additive round constant.
  function automatic logic [31:0] md5_k(input logic [5:0] rnd);
    logic [31:0] k;
    begin
      case (rnd)
        6'd0:  k = 32'hd76aa478;
        6'd1:  k = 32'he8c7b756;
        6'd2:  k = 32'h242070db;
        6'd3:  k = 32'hc1bdceee;
        6'd4:  k = 32'hf57c0faf;
        6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613;
        6'd7:  k = 32'hfd469501;
        6'd8:  k = 32'h698098d8;
        6'd9:  k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1;
        6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122;
        6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562;
        6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51;
        6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681;
        6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6;
        6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905;
        6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9;
        6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122;
        6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44;
        6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6;
        6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085;
        6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8;
        6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244;
        6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3;
        6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d;
        6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314;
        6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82;
        6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/md5sh_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module md5sh_buf import md5sh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        wr_en_i,
  input  wire logic [5:0]  wr_addr_i,
  input  wire logic [7:0]  wr_byte_i,
  input  wire logic [3:0]  rd_idx_i,
  input  wire blk_kind_e   kind_i,
  input  wire logic [5:0]  fill_i,
  input  wire logic [63:0] bit_len_i,
  output logic      [31:0] word_o
);

  logic [31:0] words_q [16];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      words_q[wr_addr_i[5:2]][{wr_addr_i[1:0], 3'b000} +: 8] <= wr_byte_i;
    end
  end

  // Padding is never stored; it is substituted byte by byte on the read side.
  always_comb begin
    logic [31:0] raw;
    logic [5:0]  bidx;
    logic [7:0]  len_byte;
    raw = words_q[rd_idx_i];
    word_o = '0;
    for (int j = 0; j < 4; j++) begin
      bidx = {rd_idx_i, 2'(j)};
      len_byte = bit_len_i[{bidx[2:0], 3'b000} +: 8];
      case (kind_i)
        KIND_DATA: word_o[8*j +: 8] = raw[8*j +: 8];
        KIND_PAD: begin
          if (bidx < fill_i) begin
            word_o[8*j +: 8] = raw[8*j +: 8];
          end else if (bidx == fill_i) begin
            word_o[8*j +: 8] = PAD_BYTE;
          end else if (bidx >= LEN_OFFSET && fill_i < LEN_OFFSET) begin
            word_o[8*j +: 8] = len_byte;
          end else begin
            word_o[8*j +: 8] = 8'h00;
          end
        end
        KIND_LEN: word_o[8*j +: 8] = (bidx >= LEN_OFFSET) ? len_byte : 8'h00;
        default:  word_o[8*j +: 8] = 8'h00;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/md5sh_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

module md5sh_round import md5sh_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire round_ctl_t   ctl_i,
  input  wire logic [31:0]  msg_word_i,
  output logic      [127:0] chain_o
);

  logic [31:0] ch_a_q, ch_b_q, ch_c_q, ch_d_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] f_val;
  logic [31:0] t_val;
  logic [63:0] rot_dbl;
  logic [31:0] b_new;

  always_comb begin
    unique case (ctl_i.rnd[5:4])
      2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f_val = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f_val = b_q ^ c_q ^ d_q;
      default: f_val = c_q ^ (b_q | ~d_q);
    endcase
  end

  assign t_val   = f_val + a_q + md5_k(ctl_i.rnd) + msg_word_i;
  assign rot_dbl = {t_val, t_val} << md5_rot(ctl_i.rnd);
  assign b_new   = b_q + rot_dbl[63:32];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q <= ch_a_q;
      b_q <= ch_b_q;
      c_q <= ch_c_q;
      d_q <= ch_d_q;
    end else if (ctl_i.step) begin
      a_q <= d_q;
      b_q <= b_new;
      c_q <= b_q;
      d_q <= c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_a_q <= IV_A;
      ch_b_q <= IV_B;
      ch_c_q <= IV_C;
      ch_d_q <= IV_D;
    end else if (ctl_i.reinit) begin
      ch_a_q <= IV_A;
      ch_b_q <= IV_B;
      ch_c_q <= IV_C;
      ch_d_q <= IV_D;
    end else if (ctl_i.fold) begin
      ch_a_q <= ch_a_q + a_q;
      ch_b_q <= ch_b_q + b_q;
      ch_c_q <= ch_c_q + c_q;
      ch_d_q <= ch_d_q + d_q;
    end
  end

  assign chain_o = {ch_d_q, ch_c_q, ch_b_q, ch_a_q};

endmodule

`default_nettype wire

// ===== rtl/core/md5_stream_hash_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake            Payload
// input    in         in_valid_i/in_stall_o  op_i, data_byte_i
// output   out        out_valid_o/out_stall_i digest_low_o, digest_high_o
//
// An absorb beat is taken at once, except the beat that fills the 64-byte block:
// input then stalls through the 64 rounds on the shared round unit and the chaining
// fold. A finish beat stalls input through the 64 rounds, the fold and the load of
// the digest register, with a reload, a second 64 rounds and a fold before that load
// when the padding spills into a second block.
// Reset loads the initial chaining words and clears the byte count and the
// sequencer; the block buffer holds no reset value.
// Absorb beats are stalled while a digest waits for the output stall to drop.

module md5_stream_hash_unit import md5sh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [63:0] digest_low_o,
  output logic      [63:0] digest_high_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_NEXT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [5:0]   rnd_q, rnd_d;
  blk_kind_e    kind_q, kind_d;
  logic         fin_q, fin_d;
  logic [63:0]  count_q, count_d;
  logic         out_valid_q, out_valid_d;
  logic [127:0] digest_q;

  round_ctl_t   ctl;
  logic         in_accept;
  logic         wr_en;
  logic         out_load;
  logic [5:0]   fill;
  logic         spill;
  logic [31:0]  msg_word;
  logic [127:0] chain;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Byte position inside the current block; the bit length is the count times eight.
  assign fill  = count_q[5:0];
  assign spill = (fill >= LEN_OFFSET);

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    kind_d     = kind_q;
    fin_d      = fin_q;
    count_d    = count_q;
    ctl        = '0;
    ctl.rnd    = rnd_q;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          ctl.load = 1'b1;
          rnd_d    = '0;
          if (op_i == OP_ABSORB) begin
            wr_en   = 1'b1;
            count_d = count_q + 64'd1;
            if (fill == 6'd63) begin
              kind_d  = KIND_DATA;
              fin_d   = 1'b0;
              state_d = S_ROUND;
            end
          end else begin
            kind_d  = KIND_PAD;
            fin_d   = 1'b1;
            state_d = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        ctl.step = 1'b1;
        rnd_d    = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        ctl.fold = 1'b1;
        if (!fin_q) begin
          state_d = S_IDLE;
        end else if (kind_q == KIND_PAD && spill) begin
          // The length did not fit: one more block of zeros and the length.
          kind_d  = KIND_LEN;
          state_d = S_NEXT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_NEXT: begin
        ctl.load = 1'b1;
        rnd_d    = '0;
        state_d  = S_ROUND;
      end
      S_DONE: begin
        // Wait until the output register is free, then restart the message.
        if (!out_valid_q || !out_stall_i) begin
          out_load   = 1'b1;
          ctl.reinit = 1'b1;
          count_d    = '0;
          fin_d      = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rnd_q       <= '0;
      kind_q      <= KIND_DATA;
      fin_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      kind_q      <= kind_d;
      fin_q       <= fin_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      digest_q <= chain;
    end
  end

  md5sh_buf u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fill),
    .wr_byte_i (data_byte_i),
    .rd_idx_i  (md5_g(rnd_q)),
    .kind_i    (kind_q),
    .fill_i    (fill),
    .bit_len_i ({count_q[60:0], 3'b000}),
    .word_o    (msg_word)
  );

  md5sh_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .msg_word_i (msg_word),
    .chain_o    (chain)
  );

  assign out_valid_o   = out_valid_q;
  assign digest_low_o  = digest_q[63:0];
  assign digest_high_o = digest_q[127:64];

`ifndef SYNTHESIS
  // The last round always hands over to the chaining fold.
  a_round_to_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == 6'd63) |=> (state_q == S_FOLD))
    else $error("last round did not lead to the fold");

  // A plain data block returns straight to accepting bytes.
  a_data_fold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOLD && !fin_q) |=> (state_q == S_IDLE))
    else $error("data block fold did not return to idle");

  // A length-only block exists only for a finish whose padding spilled.
  a_len_block_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == KIND_LEN && state_q != S_IDLE) |-> (fin_q && spill))
    else $error("length-only block without a spilled finish");

  // Emitting a digest presents it and starts a fresh message.
  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || !out_stall_i))
      |=> (out_valid_q && count_q == 64'd0 && state_q == S_IDLE))
    else $error("digest hand-off did not restart the message");
`endif

endmodule

`default_nettype wire
